// ----- design/uer_pkg.sv -----
// Shared types and constants of the ultrasonic echo ranger.
// Used by uer_core, ultrasonic_echo_ranger_unit and the test bench; no dependencies.
`timescale 1ns / 1ps

package uer_pkg;

  // no rising edge within this many ticks after the trigger pulse gives a start timeout
  localparam logic [15:0] START_TICKS = 16'd40000;

  localparam logic [7:0]  PULSE_TICKS_RST  = 8'd10;
  localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd11662;

  // register indexes on the config port
  localparam logic REG_PULSE_TICKS  = 1'b0;
  localparam logic REG_ECHO_TIMEOUT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DIST_OK      = 2'd0;
  localparam logic [1:0] ST_START_TMO    = 2'd1;
  localparam logic [1:0] ST_PULSE_TMO    = 2'd2;
  localparam logic [1:0] ST_END_B4_START = 2'd3;

  // mm = floor((count*343 + 1000) / 2000), done as (count*343*M + 1000*M) >> 36
  // with M = ceil(2^36 / 2000); exact for every 16-bit count
  localparam int unsigned DIST_SHIFT = 36;
  localparam logic [49:0] DIST_MUL = 50'd11785390477;
  localparam logic [49:0] DIST_ADD = 50'd34359739000;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0]  pulse_ticks;
    logic [15:0] echo_timeout;
  } cfg_t;

  typedef struct packed {
    logic [13:0] distance_mm;
    logic [1:0]  status;
    logic        done_res;
    logic        trigger_out;
  } res_t;

endpackage

// ----- design/uer_core.sv -----
// Ranging sequencer: phase, tick counter and echo edge tracking, plus the
// count to millimetre conversion. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          start_request_i,
  input  logic          echo_level_i,
  input  uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t res_o
);

  uer_pkg::phase_e phase_q, phase_d;
  logic [15:0]     tick_q, tick_d;
  logic            last_echo_q;

  logic        rising, falling;
  logic        pulse_short;
  logic [15:0] plen;
  logic [15:0] tick_inc;
  logic [15:0] meas_cnt;
  logic [49:0] dist_prod;

  assign rising      = echo_level_i & ~last_echo_q;
  assign falling     = ~echo_level_i & last_echo_q;
  // a zero pulse length acts as one tick
  assign pulse_short = (cfg_i.pulse_ticks <= 8'd1);
  assign plen        = pulse_short ? 16'd1 : {8'd0, cfg_i.pulse_ticks};
  assign tick_inc    = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign meas_cnt    = rising ? 16'd0 : tick_inc;
  assign dist_prod   = {34'd0, meas_cnt} * uer_pkg::DIST_MUL + uer_pkg::DIST_ADD;

  always_comb begin
    phase_d           = phase_q;
    tick_d            = tick_q;
    res_o.trigger_out = 1'b0;
    res_o.done_res    = 1'b0;
    res_o.status      = uer_pkg::ST_DIST_OK;
    res_o.distance_mm = 14'd0;
    unique case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (start_request_i) begin
          res_o.trigger_out = 1'b1;
          if (pulse_short) begin
            phase_d = uer_pkg::PH_WAIT;
            tick_d  = 16'd0;
          end else begin
            phase_d = uer_pkg::PH_TRIG;
            tick_d  = 16'd1;
          end
        end
      end
      uer_pkg::PH_TRIG: begin
        res_o.trigger_out = 1'b1;
        if (tick_inc >= plen) begin
          phase_d = uer_pkg::PH_WAIT;
          tick_d  = 16'd0;
        end else begin
          tick_d = tick_inc;
        end
      end
      uer_pkg::PH_WAIT: begin
        tick_d = tick_inc;
        if (rising) begin
          phase_d = uer_pkg::PH_MEAS;
          tick_d  = 16'd0;
        end else if (tick_inc >= uer_pkg::START_TICKS) begin
          res_o.done_res = 1'b1;
          res_o.status   = uer_pkg::ST_START_TMO;
        end else if (falling) begin
          res_o.done_res = 1'b1;
          res_o.status   = uer_pkg::ST_END_B4_START;
        end
      end
      uer_pkg::PH_MEAS: begin
        // a second rising edge restarts the count
        tick_d = meas_cnt;
        if (meas_cnt >= cfg_i.echo_timeout) begin
          res_o.done_res = 1'b1;
          res_o.status   = uer_pkg::ST_PULSE_TMO;
        end else if (falling) begin
          res_o.done_res    = 1'b1;
          res_o.status      = uer_pkg::ST_DIST_OK;
          res_o.distance_mm = dist_prod[uer_pkg::DIST_SHIFT +: 14];
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
        tick_d  = 16'd0;
      end
    endcase
    if (res_o.done_res) begin
      phase_d = uer_pkg::PH_IDLE;
      tick_d  = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= uer_pkg::PH_IDLE;
      tick_q      <= 16'd0;
      last_echo_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      last_echo_q <= echo_level_i;
    end
  end

endmodule

// ----- design/ultrasonic_echo_ranger_unit.sv -----
// Ultrasonic echo ranger: one item per microsecond tick in, one result item out.
// An item passes the input register and then the result register before its result
// is valid. Throughput: one item per cycle, bounded only by output stalls.
// Reset: phase idle, counters and echo history cleared, pulse_ticks = 10,
// echo_timeout = 11662, both pipeline registers empty.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_request, [1] echo_level, rest zero
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] trigger_out, [1] done_res, [3:2] status,
                                      // [17:4] distance_mm, rest zero
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  uer_pkg::cfg_t cfg_q;
  uer_pkg::res_t res, res_q;

  logic in_valid_q, in_req_q, in_echo_q;
  logic out_valid_q;
  logic advance, fire, cfg_wr;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ticks  <= uer_pkg::PULSE_TICKS_RST;
      cfg_q.echo_timeout <= uer_pkg::ECHO_TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        uer_pkg::REG_PULSE_TICKS:  cfg_q.pulse_ticks  <= pwdata[7:0];
        uer_pkg::REG_ECHO_TIMEOUT: cfg_q.echo_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      uer_pkg::REG_PULSE_TICKS:  prdata = {24'd0, cfg_q.pulse_ticks};
      uer_pkg::REG_ECHO_TIMEOUT: prdata = {16'd0, cfg_q.echo_timeout};
      default:                   prdata = 32'd0;
    endcase
  end

  // two-register pipeline; while a result waits, the input side takes an item only into an empty input register
  assign advance       = ~out_valid_q | m_axis_tready;
  assign fire          = in_valid_q & advance;
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q  <= s_axis_tdata[0];
      in_echo_q <= s_axis_tdata[1];
    end
    if (fire) begin
      res_q <= res;
    end
  end

  uer_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (fire),
    .start_request_i (in_req_q),
    .echo_level_i    (in_echo_q),
    .cfg_i           (cfg_q),
    .res_o           (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q};

  // a held item must not be dropped while the result side is stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_req_q) && $stable(in_echo_q))
    else $error("input item lost during stall");

  // an item leaving the input register must show up as a result
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("item advanced but no result valid");

  // trigger phases never finish a measurement
  a_trig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_q.trigger_out && res_q.done_res))
    else $error("trigger and done in one result");

endmodule

// ----- tb/ultrasonic_echo_ranger_unit_test.sv -----
// Self-checking bench for ultrasonic_echo_ranger_unit: stream items in, result items out,
// checked against a tick-exact predictor. Depends on uer_pkg and the ranger RTL only.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_unit_test;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned IDLE_PCT    = 17;
  localparam uer_pkg::res_t RES_IDLE = '0;
  localparam uer_pkg::res_t RES_TRIG = {14'd0, 2'b00, 1'b0, 1'b1};

  typedef enum logic { ROW_TICKS, ROW_CFG } row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic          req;
    logic          echo;
    logic [16:0]   reps;
    bit            typed;   // last tick of the row has a hand-written result
    uer_pkg::res_t want;
    logic          reg_idx;
    logic [15:0]   reg_val;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [0] start_request, [1] echo_level, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [0] trigger_out, [1] done_res, [3:2] status,
                                      // [17:4] distance_mm, rest zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ultrasonic_echo_ranger_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ranger state as the predictor sees it
  uer_pkg::phase_e rng_phase = uer_pkg::PH_IDLE;
  logic [15:0]     rng_count = '0;
  logic            rng_echo_prev = 1'b0;
  logic [7:0]      cfg_pulse = uer_pkg::PULSE_TICKS_RST;
  logic [15:0]     cfg_timeout = uer_pkg::ECHO_TIMEOUT_RST;

  uer_pkg::res_t pending_res[$];
  stim_row_t     stim_rows[$];
  bit            calm = 1'b0;
  int unsigned   errors = 0;
  int unsigned   items_sent = 0;
  int unsigned   done_total = 0;
  int unsigned   cfg_writes = 0;
  int unsigned   cycles = 0;
  uer_pkg::res_t mon_got, mon_want;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // one microsecond tick of the ranger
  function automatic uer_pkg::res_t ranger_tick(input logic req, input logic echo);
    logic          rising, falling;
    logic [7:0]    plen;
    int unsigned   mm;
    uer_pkg::res_t r;
    rising  = echo && !rng_echo_prev;
    falling = !echo && rng_echo_prev;
    plen    = (cfg_pulse == 8'd0) ? 8'd1 : cfg_pulse;
    r       = RES_IDLE;
    case (rng_phase)
      uer_pkg::PH_IDLE: begin
        if (req) begin
          r.trigger_out = 1'b1;
          rng_count = 16'd1;
          if (rng_count >= plen) begin
            rng_phase = uer_pkg::PH_WAIT;
            rng_count = '0;
          end else begin
            rng_phase = uer_pkg::PH_TRIG;
          end
        end
      end
      uer_pkg::PH_TRIG: begin
        r.trigger_out = 1'b1;
        rng_count = bump(rng_count);
        if (rng_count >= plen) begin
          rng_phase = uer_pkg::PH_WAIT;
          rng_count = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        rng_count = bump(rng_count);
        if (rising) begin
          rng_phase = uer_pkg::PH_MEAS;
          rng_count = '0;
        end else if (rng_count >= uer_pkg::START_TICKS) begin
          r.done_res = 1'b1;
          r.status = uer_pkg::ST_START_TMO;
        end else if (falling) begin
          r.done_res = 1'b1;
          r.status = uer_pkg::ST_END_B4_START;
        end
      end
      default: begin
        rng_count = rising ? 16'd0 : bump(rng_count);
        if (rng_count >= cfg_timeout) begin
          r.done_res = 1'b1;
          r.status = uer_pkg::ST_PULSE_TMO;
        end else if (falling) begin
          mm = (32'(rng_count) * 343 + 1000) / 2000;
          r.done_res = 1'b1;
          r.status = uer_pkg::ST_DIST_OK;
          r.distance_mm = mm[13:0];
        end
      end
    endcase
    if (r.done_res) begin
      rng_phase = uer_pkg::PH_IDLE;
      rng_count = '0;
      done_total++;
    end
    rng_echo_prev = echo;
    return r;
  endfunction

  function automatic void tick_row(input logic req, input logic echo, input int unsigned reps,
                                   input bit typed, input uer_pkg::res_t want);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_TICKS;
    r.req   = req;
    r.echo  = echo;
    r.reps  = reps[16:0];
    r.typed = typed;
    r.want  = want;
    stim_rows.push_back(r);
  endfunction

  function automatic void cfg_row(input logic idx, input logic [15:0] val);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    stim_rows.push_back(r);
  endfunction

  task automatic send_item(input logic req, input logic echo, input bit typed,
                           input uer_pkg::res_t want);
    uer_pkg::res_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, echo, req};
    do @(posedge clk_i); while (!s_axis_tready);
    r = ranger_tick(req, echo);
    pending_res.push_back(typed ? want : r);
    items_sent++;
  endtask

  // drain, then write one register and read it back
  task automatic write_reg(input logic idx, input logic [15:0] val);
    logic [31:0] readback;
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == uer_pkg::REG_PULSE_TICKS) cfg_pulse = val[7:0];
    else                                 cfg_timeout = val;
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = (idx == uer_pkg::REG_PULSE_TICKS) ? {24'd0, val[7:0]} : {16'd0, val};
    if (prdata !== readback) begin
      $error("prdata: expected %0d, got %0d", readback, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one trigger/echo sequence with random shape; some are noise or broken on purpose
  task automatic run_measurement();
    int unsigned style, plen, gap, width, wmax, n, i;
    style = $urandom_range(9);
    if (style == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, RES_IDLE);
    end else begin
      plen = (cfg_pulse == 8'd0) ? 1 : cfg_pulse;
      send_item(1'b1, 1'b0, 1'b0, RES_IDLE);
      // broken style lets the echo wander during the pulse
      for (i = 1; i < plen; i++)
        send_item($urandom_range(3) == 0, (style == 1) ? 1'($urandom_range(1)) : 1'b0,
                  1'b0, RES_IDLE);
      gap = $urandom_range(0, 4);
      repeat (gap) send_item($urandom_range(3) == 0, 1'b0, 1'b0, RES_IDLE);
      wmax  = (cfg_timeout > 16'd100) ? 100 : cfg_timeout + 2;
      width = $urandom_range(1, wmax);
      repeat (width) send_item($urandom_range(3) == 0, 1'b1, 1'b0, RES_IDLE);
      send_item(1'($urandom_range(1)), 1'b0, 1'b0, RES_IDLE);
      n = $urandom_range(0, 3);
      repeat (n) send_item(1'b0, 1'b0, 1'b0, RES_IDLE);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        $error("result item with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        mon_want = pending_res.pop_front();
        mon_got  = m_axis_tdata[17:0];
        if (mon_got.trigger_out !== mon_want.trigger_out) begin
          $error("trigger_out: expected %0d, got %0d", mon_want.trigger_out, mon_got.trigger_out);
          errors++;
        end
        if (mon_got.done_res !== mon_want.done_res) begin
          $error("done_res: expected %0d, got %0d", mon_want.done_res, mon_got.done_res);
          errors++;
        end
        if (mon_got.status !== mon_want.status) begin
          $error("status: expected %0d, got %0d", mon_want.status, mon_got.status);
          errors++;
        end
        if (mon_got.distance_mm !== mon_want.distance_mm) begin
          $error("distance_mm: expected %0d, got %0d", mon_want.distance_mm, mon_got.distance_mm);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ultrasonic_echo_ranger_unit_test: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned k, ph, ph_start, rand_start, dones_start, rand_items, rand_dones;
    logic [7:0]  p_val;
    logic [15:0] t_val;

    // reset values of the block
    tick_row(1'b0, 1'b0, 1, 1'b1, RES_IDLE);
    tick_row(1'b1, 1'b0, 1, 1'b1, RES_TRIG);
    // requests and echo ignored while the pulse runs, echo left high at its end
    tick_row(1'b1, 1'b1, 9, 1'b1, RES_TRIG);
    tick_row(1'b0, 1'b1, 3, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b0, 1, 1'b1, {14'd0, uer_pkg::ST_END_B4_START, 1'b1, 1'b0});
    tick_row(1'b1, 1'b0, 10, 1'b1, RES_TRIG);
    tick_row(1'b0, 1'b0, 5, 1'b0, RES_IDLE);
    tick_row(1'b1, 1'b1, 40, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b0, 1, 1'b0, RES_IDLE);
    // request on the finishing tick is dropped
    tick_row(1'b1, 1'b0, 10, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b1, 1, 1'b0, RES_IDLE);
    tick_row(1'b1, 1'b0, 1, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b0, 1, 1'b1, RES_IDLE);
    // zero pulse length acts as one tick
    cfg_row(uer_pkg::REG_PULSE_TICKS, 16'd0);
    tick_row(1'b1, 1'b0, 1, 1'b1, RES_TRIG);
    // zero echo timeout expires right after the rising edge
    cfg_row(uer_pkg::REG_ECHO_TIMEOUT, 16'd0);
    tick_row(1'b0, 1'b1, 1, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b1, 1, 1'b1, {14'd0, uer_pkg::ST_PULSE_TMO, 1'b1, 1'b0});
    // widest echo timeout, echo well below it
    cfg_row(uer_pkg::REG_ECHO_TIMEOUT, 16'hFFFF);
    tick_row(1'b1, 1'b0, 1, 1'b1, RES_TRIG);
    tick_row(1'b0, 1'b1, 60, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b0, 1, 1'b0, RES_IDLE);
    // echo already high when the pulse ends, its fall ends before start
    tick_row(1'b1, 1'b1, 1, 1'b1, RES_TRIG);
    tick_row(1'b0, 1'b1, 20, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b0, 1, 1'b1, {14'd0, uer_pkg::ST_END_B4_START, 1'b1, 1'b0});
    cfg_row(uer_pkg::REG_PULSE_TICKS, 16'd255);
    cfg_row(uer_pkg::REG_ECHO_TIMEOUT, 16'd3);
    tick_row(1'b1, 1'b0, 255, 1'b1, RES_TRIG);
    tick_row(1'b0, 1'b1, 3, 1'b0, RES_IDLE);
    tick_row(1'b0, 1'b1, 1, 1'b1, {14'd0, uer_pkg::ST_PULSE_TMO, 1'b1, 1'b0});
    tick_row(1'b0, 1'b0, 1, 1'b1, RES_IDLE);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_val);
      end else begin
        for (k = 0; k < stim_rows[r].reps; k++)
          send_item(stim_rows[r].req, stim_rows[r].echo,
                    stim_rows[r].typed && (k == stim_rows[r].reps - 1), stim_rows[r].want);
      end
    end

    rand_start  = items_sent;
    dones_start = done_total;
    ph = 0;
    while (ph < 8) begin
      case (ph % 8)
        0:       begin p_val = 8'd1;   t_val = 16'($urandom_range(5, 60)); end
        1:       begin p_val = 8'd0;   t_val = 16'd1; end
        2:       begin p_val = 8'd2;   t_val = 16'hFFFF; end
        3:       begin p_val = 8'($urandom_range(1, 12)); t_val = 16'($urandom_range(5, 60)); end
        4:       begin p_val = 8'($urandom_range(2, 6));  t_val = 16'd0; end
        5:       begin p_val = 8'd1;   t_val = 16'($urandom_range(1, 150)); end
        6:       begin p_val = 8'($urandom_range(1, 12)); t_val = uer_pkg::ECHO_TIMEOUT_RST; end
        default: begin p_val = 8'($urandom_range(40)); t_val = 16'($urandom_range(1, 65535)); end
      endcase
      write_reg(uer_pkg::REG_PULSE_TICKS, {8'd0, p_val});
      write_reg(uer_pkg::REG_ECHO_TIMEOUT, t_val);
      // one stretch runs with both sides always ready
      calm = (ph % 8 == 3);
      ph_start = items_sent;
      while (items_sent - ph_start < 40) run_measurement();
      calm = 1'b0;
      ph++;
    end
    rand_items = items_sent - rand_start;
    rand_dones = done_total - dones_start;

    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    $display("covered %0d items, %0d of them random over %0d register settings",
             items_sent, rand_items, ph);
    $display("finished measurements: %0d in total, %0d in the random part; %0d register writes",
             done_total, rand_dones, cfg_writes);
    if (errors == 0) begin
      $display("ultrasonic_echo_ranger_unit_test: done, clean");
    end else begin
      $display("ultrasonic_echo_ranger_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- ultrasonic_echo_ranger_unit.f -----
design/uer_pkg.sv
design/uer_core.sv
design/ultrasonic_echo_ranger_unit.sv
tb/ultrasonic_echo_ranger_unit_test.sv
